// ===== rtl/core/wpm_pkg.sv =====
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// no dependencies; imported by the cell and the top level

package wpm_pkg;

    // input beat opcodes
    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic CFG_STAR = 1'b0;
    localparam logic CFG_ANY  = 1'b1;

    localparam logic [7:0] STAR_RESET = 8'd42;
    localparam logic [7:0] ANY_RESET  = 8'd63;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       restart;
        logic [7:0] ch;
        logic [7:0] star_code;
        logic [7:0] any_code;
    } t_cell_ctrl;

    // handed from one cell to its right neighbor
    typedef struct packed {
        logic strobe;   // neighbor updated its match bit at the last edge
        logic m_old;    // neighbor match bit before that update
        logic m_new;    // neighbor match bit after that update
        logic e;        // neighbor empty-text bit
    } t_link;

endpackage

// ===== rtl/core/wpm_ifs.sv =====
// wpm_in_if / wpm_out_if: valid-ready channels of the wildcard pattern matcher
// depends on nothing but the clock-free handshake signals declared here

interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] in_char;

    modport source (output valid, output action, output in_char, input ready);
    modport sink   (input valid, input action, input in_char, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

// ===== rtl/core/wpm_cell.sv =====
// wpm_cell: one pattern position of the matcher chain
// holds a pattern char, its match and empty-text bits; uses wpm_pkg types

module wpm_cell
    import wpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_sel,
    input  t_link      i_left,
    output t_link      o_right,
    output logic       o_m
);

    logic [7:0] r_p;
    logic       r_valid;
    logic       r_m;
    logic       r_m_old;
    logic       r_e;
    logic       r_strobe;

    logic       n_m;
    logic       n_e;
    logic       w_lit;
    logic       w_star;

    always_comb begin
        w_lit  = r_valid && ((r_p == i_ctrl.ch) || (r_p == i_ctrl.any_code));
        w_star = r_valid && (r_p == i_ctrl.star_code);
        n_e    = i_left.e && (i_ctrl.ch == i_ctrl.star_code);
        // literal wins over star
        if (w_lit) begin
            n_m = i_left.m_old;
        end else if (w_star) begin
            n_m = r_m | i_left.m_new;
        end else begin
            n_m = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_m      <= 1'b0;
            r_m_old  <= 1'b0;
            r_e      <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_left.strobe;
            if (i_ctrl.clear) begin
                r_valid <= 1'b0;
                r_m     <= 1'b0;
                r_e     <= 1'b0;
            end else if (i_ctrl.append) begin
                if (i_sel) begin
                    r_valid <= 1'b1;
                    r_e     <= n_e;
                    r_m     <= n_e;
                end else begin
                    r_m <= r_e;
                end
            end else if (i_ctrl.restart) begin
                r_m <= r_e;
            end else if (i_left.strobe) begin
                r_m_old <= r_m;
                r_m     <= n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && i_sel) begin
            r_p <= i_ctrl.ch;
        end
    end

    assign o_right.strobe = r_strobe;
    assign o_right.m_old  = r_m_old;
    assign o_right.m_new  = r_m;
    assign o_right.e      = r_e;
    assign o_m            = r_m;

endmodule

// ===== rtl/core/wildcard_pattern_matcher.sv =====
// wildcard_pattern_matcher: top level, head of the cell chain and beat handshake
// depends on wpm_pkg, wpm_ifs.sv (wpm_in_if, wpm_out_if) and wpm_cell

// The matcher keeps a wildcard pattern of up to PATTERN_CAPACITY characters in a
// chain of cells, one cell per pattern position, and returns one result beat per
// input beat: matched (the whole pattern matches the text since the last restart,
// append or clear beat) and the sticky overflow flag. Append, clear and restart
// beats load their result as soon as the output is free. A text beat sweeps the
// chain as a wavefront, one cell per cycle, and its result is loaded once the
// wavefront leaves the last cell and the output is free; the length of the cell
// chain sets how long the sweep runs. One beat is worked on at a time; a new beat
// is taken while the previous result still waits on the output.
// Pattern chars beyond capacity are dropped and set overflow, which forces
// matched low until a clear beat. Write star_code and any_code only while idle.

module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int PATTERN_CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    wpm_in_if.sink          i_in,
    wpm_out_if.source       o_out
);

    localparam int CW = $clog2(PATTERN_CAPACITY + 1);

    // configuration
    logic [7:0]    r_star_code;
    logic [7:0]    r_any_code;

    // head of the chain: pattern prefix of length zero
    logic          r_m0;
    logic          r_hd_strobe;
    logic          r_hd_old;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [7:0]    r_char;

    // beat sequencing
    logic          r_busy;
    logic          r_fin;
    logic          r_out_valid;
    logic          r_matched;
    logic          r_overflow;

    logic          w_accept;
    logic          w_full;
    logic          w_finish;
    t_action       w_action;
    t_cell_ctrl    w_ctrl;
    t_link         w_link [0:PATTERN_CAPACITY];
    logic [PATTERN_CAPACITY:0] w_m;

    assign w_action = t_action'(i_in.action);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_full   = (r_count == CW'(PATTERN_CAPACITY));
    assign w_finish = r_fin && (!r_out_valid || o_out.ready);

    assign i_in.ready = !r_busy;

    // broadcast controls; text char is held in r_char during a sweep
    always_comb begin
        w_ctrl.clear     = w_accept && (w_action == ACT_CLEAR);
        w_ctrl.append    = w_accept && (w_action == ACT_APPEND);
        w_ctrl.restart   = w_accept && (w_action == ACT_RESTART);
        w_ctrl.ch        = w_accept ? i_in.in_char : r_char;
        w_ctrl.star_code = r_star_code;
        w_ctrl.any_code  = r_any_code;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star_code <= STAR_RESET;
            r_any_code  <= ANY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STAR: r_star_code <= i_cfg_data;
                CFG_ANY:  r_any_code  <= i_cfg_data;
                default:  r_star_code <= r_star_code;
            endcase
        end
    end

    // head state, pattern length and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0        <= 1'b1;
            r_hd_strobe <= 1'b0;
            r_hd_old    <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_hd_strobe <= 1'b0;
            if (w_accept) begin
                unique case (w_action)
                    ACT_APPEND: begin
                        r_m0 <= 1'b1;
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    ACT_TEXT: begin
                        // empty prefix never matches a non-empty text
                        r_hd_strobe <= 1'b1;
                        r_hd_old    <= r_m0;
                        r_m0        <= 1'b0;
                    end
                    ACT_CLEAR: begin
                        r_m0    <= 1'b1;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                    ACT_RESTART: begin
                        r_m0 <= 1'b1;
                    end
                    default: begin
                        r_m0 <= r_m0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_in.in_char;
        end
    end

    // chain of cells, the head feeds cell 1
    assign w_link[0].strobe = r_hd_strobe;
    assign w_link[0].m_old  = r_hd_old;
    assign w_link[0].m_new  = 1'b0;
    assign w_link[0].e      = 1'b1;
    assign w_m[0]           = r_m0;

    for (genvar k = 1; k <= PATTERN_CAPACITY; k++) begin : g_cell
        wpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_sel   (r_count == CW'(k - 1)),
            .i_left  (w_link[k-1]),
            .o_right (w_link[k]),
            .o_m     (w_m[k])
        );
    end

    // beat sequencing: busy from accept until the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                // text beats finish once the wavefront leaves the last cell
                r_fin  <= (w_action != ACT_TEXT);
            end else if (w_finish) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
            end else if (w_link[PATTERN_CAPACITY].strobe) begin
                r_fin <= 1'b1;
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, match bit of the full-length prefix
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_matched  <= !r_ovf && w_m[r_count];
            r_overflow <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.matched  = r_matched;
    assign o_out.overflow = r_overflow;

endmodule
